// ===== rtl/core/tmmp_pkg.sv =====
// shared types, constants and tables for the trackball motion mode processor
`default_nettype none
package tmmp_pkg;

    localparam int ANGLE_COUNT_DEF   = 13;
    localparam int DIVIDER_COUNT_DEF = 5;
    localparam int FRAC_BITS_DEF     = 16;

    localparam logic [3:0]  ROT_RESET    = 4'd3;
    localparam logic [2:0]  DIV_RESET    = 3'd1;
    localparam logic        INV_RESET    = 1'b1;
    localparam logic [15:0] SMOOTH_RESET = 16'd45875;

    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_DIVIDER  = 2'd1;
    localparam logic [1:0] REG_INVERT   = 2'd2;
    localparam logic [1:0] REG_SMOOTH   = 2'd3;

    localparam logic [1:0] MODE_CURSOR     = 2'd0;
    localparam logic [1:0] MODE_SCROLL     = 2'd1;
    localparam logic [1:0] MODE_VOLUME     = 2'd2;
    localparam logic [1:0] MODE_BRIGHTNESS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SMOOTH,
        ST_MODE,
        ST_OUTPUT,
        ST_HOLD
    } tmmp_state_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic smooth;
        logic mode;
        logic output_calc;
    } tmmp_cmd_t;

    function automatic logic signed [7:0] angle_deg(input logic [4:0] idx);
        logic signed [7:0] d;
        begin
            case (idx)
                5'd0:    d = -8'sd90;
                5'd1:    d = -8'sd75;
                5'd2:    d = -8'sd60;
                5'd3:    d = -8'sd45;
                5'd4:    d = -8'sd30;
                5'd5:    d = -8'sd15;
                5'd6:    d = 8'sd0;
                5'd7:    d = 8'sd15;
                5'd8:    d = 8'sd30;
                5'd9:    d = 8'sd45;
                5'd10:   d = 8'sd60;
                5'd11:   d = 8'sd75;
                default: d = 8'sd90;
            endcase
            return d;
        end
    endfunction

    function automatic logic [16:0] sine_q16(input logic [2:0] k);
        logic [16:0] s;
        begin
            case (k)
                3'd0:    s = 17'd0;
                3'd1:    s = 17'd16962;
                3'd2:    s = 17'd32768;
                3'd3:    s = 17'd46341;
                3'd4:    s = 17'd56756;
                3'd5:    s = 17'd63303;
                default: s = 17'd65536;
            endcase
            return s;
        end
    endfunction

    function automatic logic [6:0] divisor(input logic [3:0] idx);
        logic [6:0] d;
        begin
            case (idx)
                4'd0:    d = 7'd16;
                4'd1:    d = 7'd24;
                4'd2:    d = 7'd32;
                4'd3:    d = 7'd48;
                default: d = 7'd64;
            endcase
            return d;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tmmp_ctrl.sv =====
// controller state machine sequencing one report through the datapath
`default_nettype none
module tmmp_ctrl
    import tmmp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output tmmp_cmd_t      cmd
);

    tmmp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_ROTATE;
            ST_ROTATE: state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_MODE;
            ST_MODE:   state_next = ST_OUTPUT;
            ST_OUTPUT: state_next = ST_HOLD;
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = in_valid ? ST_ROTATE : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ROTATE: cmd.rotate      = 1'b1;
            ST_SMOOTH: cmd.smooth      = 1'b1;
            ST_MODE:   cmd.mode        = 1'b1;
            ST_OUTPUT: cmd.output_calc = 1'b1;
            ST_HOLD:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                cmd.load  = out_ready && in_valid;
            end
            default: ;
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cmd.rotate && !cmd.smooth)
        else $error("result shown while datapath busy");
    a_load_then_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.rotate)
        else $error("load not followed by rotation");
    a_output_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.output_calc |=> out_valid)
        else $error("result not presented");

endmodule
`default_nettype wire

// ===== rtl/core/tmmp_datapath.sv =====
// datapath: rotation, smoothers, mode accumulators and result registers
`default_nettype none
module tmmp_datapath
    import tmmp_pkg::*;
#(
    parameter int ANGLE_COUNT   = ANGLE_COUNT_DEF,
    parameter int DIVIDER_COUNT = DIVIDER_COUNT_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tmmp_cmd_t         cmd,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_idx,
    input  wire logic [15:0]       cfg_data,
    input  wire logic signed [7:0] move_x,
    input  wire logic signed [7:0] move_y,
    input  wire logic              want_volume,
    input  wire logic              want_brightness,
    input  wire logic              want_scroll,
    output logic signed [7:0]      cursor_dx,
    output logic signed [7:0]      cursor_dy,
    output logic signed [7:0]      scroll_h,
    output logic signed [7:0]      scroll_v,
    output logic signed [4:0]      volume_steps,
    output logic signed [4:0]      brightness_steps,
    output logic [1:0]             current_mode
);

    localparam int AMAX = ((ANGLE_COUNT < 13) ? ANGLE_COUNT : 13) - 1;
    localparam int DMAX = ((DIVIDER_COUNT < 5) ? DIVIDER_COUNT : 5) - 1;
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint CUR_DB = (ONE * 2 + 50) / 100;
    localparam longint MODE_DB = (ONE + 50) / 100;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;

    logic [3:0]  rot_reg;
    logic [2:0]  div_reg;
    logic        inv_reg;
    logic [15:0] fac_reg;

    logic signed [31:0] cfx_reg, cfy_reg, mfx_reg, mfy_reg;
    logic signed [31:0] crx_reg, cry_reg, srx_reg, sry_reg, vol_reg, brt_reg;
    logic [1:0]  prev_reg, mode_reg;
    logic signed [7:0] x_reg, y_reg;
    logic signed [47:0] rx_reg, ry_reg;
    logic signed [31:0] cx_reg, cy_reg, t0_reg, t1_reg;

    function automatic longint floor_shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint round_shr(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input longint v);
        logic signed [31:0] r;
        begin
            if (v > S32MAX) r = 32'h7fffffff;
            else if (v < S32MIN) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint deadband(input longint v, input longint thr);
        return (mag(v) < thr) ? 64'sd0 : v;
    endfunction

    function automatic longint q16_fx(input longint v);
        longint r;
        begin
            if (FRAC_BITS >= 16) r = v <<< ((FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0);
            else r = round_shr(v, (FRAC_BITS < 16) ? 16 - FRAC_BITS : 1);
            return r;
        end
    endfunction

    function automatic longint smooth(input logic signed [31:0] prev, input longint in_v,
                                      input logic [15:0] f);
        return round_shr(longint'(prev) * longint'({1'b0, f})
                         + in_v * (64'sd65536 - longint'({1'b0, f})), 16);
    endfunction

    // whole units out of a remainder, truncated toward zero, count limited to lim
    // unit is 2^(FRAC_BITS+sh), times three when three is set
    function automatic logic signed [8:0] take_q(input logic signed [31:0] r,
                                                 input logic [2:0] sh, input logic three,
                                                 input logic [7:0] lim);
        logic [31:0] a;
        logic [31:0] q;
        logic [16:0] p;
        logic [8:0]  m;
        begin
            a = r[31] ? $unsigned(-r) : $unsigned(r);
            q = a >> (FRAC_BITS + int'(sh));
            if (q > 32'd511) q = 32'd511;
            p = {8'd0, q[8:0]} * 17'd171;
            if (three) q = {24'd0, p[16:9]};
            if (q > {24'd0, lim}) q = {24'd0, lim};
            m = q[8:0];
            return r[31] ? -$signed(m) : $signed(m);
        end
    endfunction

    logic [4:0] ai;
    logic [3:0] di;
    logic signed [7:0] deg;
    logic [2:0] k;
    logic signed [17:0] sn, cs;
    longint rx_c, ry_c;

    always_comb
    begin
        ai = (rot_reg > 4'(AMAX)) ? 5'(AMAX) : {1'b0, rot_reg};
        di = ({1'b0, div_reg} > 4'(DMAX)) ? 4'(DMAX) : {1'b0, div_reg};
        deg = angle_deg(ai);
        k = (ai >= 5'd6) ? 3'(ai - 5'd6) : 3'(5'd6 - ai);
        sn = (deg < 0) ? -$signed({1'b0, sine_q16(k)}) : $signed({1'b0, sine_q16(k)});
        cs = $signed({1'b0, sine_q16(3'(6 - k))});
        rx_c = q16_fx(-(longint'(x_reg) * longint'(cs) + longint'(y_reg) * longint'(sn)));
        ry_c = q16_fx(longint'(y_reg) * longint'(cs) - longint'(x_reg) * longint'(sn));
    end

    logic [1:0] mode_c;
    always_comb
    begin
        if (want_volume) mode_c = MODE_VOLUME;
        else if (want_brightness) mode_c = MODE_BRIGHTNESS;
        else if (want_scroll) mode_c = MODE_SCROLL;
        else mode_c = MODE_CURSOR;
    end

    logic mode_change;
    logic signed [31:0] mfx_seed, mfy_seed;
    assign mode_change = (mode_reg != prev_reg);
    assign mfx_seed = mode_change ? sat32(64'(rx_reg)) : mfx_reg;
    assign mfy_seed = mode_change ? sat32(64'(ry_reg)) : mfy_reg;

    // accumulate into the active remainders
    longint fv, fb, hx, vy, gx, gy, t0, t1;
    always_comb
    begin
        fv = deadband(longint'(mfy_reg), MODE_DB);
        fb = fv;
        hx = longint'(mfx_reg);
        vy = longint'(mfy_reg);
        if (mag(hx) > mag(vy)) vy = 0; else hx = 0;
        hx = deadband(hx, MODE_DB);
        vy = deadband(vy, MODE_DB);
        if (inv_reg) vy = -vy; else hx = -hx;
        gx = deadband(floor_shr(longint'(cx_reg) * 3, 1), CUR_DB);
        gy = deadband(floor_shr(longint'(cy_reg) * 3, 1), CUR_DB);
        t0 = 0;
        t1 = 0;
        case (mode_reg)
            MODE_VOLUME:
            begin
                t0 = longint'(sat32(longint'(vol_reg) - round_shr(fv * 328, 16)));
            end
            MODE_BRIGHTNESS:
            begin
                t0 = longint'(sat32(longint'(brt_reg) - round_shr(fb * 1311, 16)));
            end
            MODE_SCROLL:
            begin
                t0 = longint'(sat32(longint'(srx_reg) + round_shr(hx * 22938, 16)));
                t1 = longint'(sat32(longint'(sry_reg) + round_shr(vy * 22938, 16)));
            end
            default:
            begin
                t0 = longint'(sat32(longint'(crx_reg) + round_shr(gx, 1)));
                t1 = longint'(sat32(longint'(cry_reg) + round_shr(gy, 1)));
            end
        endcase
    end

    // take whole units out of the accumulated remainders
    logic [6:0] dv;
    logic [2:0] dv_sh;
    logic       dv_three;
    logic [7:0] lim;
    logic signed [8:0]  n0, n1;
    logic signed [16:0] nd0, nd1;
    logic signed [31:0] rem0, rem1;
    always_comb
    begin
        dv       = 7'd1;
        dv_sh    = 3'd0;
        dv_three = 1'b0;
        lim      = 8'd127;
        case (mode_reg)
            MODE_SCROLL:
            begin
                dv = divisor(di);
                case (dv)
                    7'd24:
                    begin
                        dv_sh    = 3'd3;
                        dv_three = 1'b1;
                    end
                    7'd32: dv_sh = 3'd5;
                    7'd48:
                    begin
                        dv_sh    = 3'd4;
                        dv_three = 1'b1;
                    end
                    7'd64: dv_sh = 3'd6;
                    default: dv_sh = 3'd4;
                endcase
            end
            MODE_VOLUME, MODE_BRIGHTNESS: lim = 8'd8;
            default: ;
        endcase
        n0   = take_q(t0_reg, dv_sh, dv_three, lim);
        n1   = take_q(t1_reg, dv_sh, dv_three, lim);
        nd0  = n0 * $signed({1'b0, dv});
        nd1  = n1 * $signed({1'b0, dv});
        rem0 = sat32(longint'(t0_reg) - (longint'(nd0) <<< FRAC_BITS));
        rem1 = sat32(longint'(t1_reg) - (longint'(nd1) <<< FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg  <= ROT_RESET;
            div_reg  <= DIV_RESET;
            inv_reg  <= INV_RESET;
            fac_reg  <= SMOOTH_RESET;
            cfx_reg  <= '0;
            cfy_reg  <= '0;
            mfx_reg  <= '0;
            mfy_reg  <= '0;
            crx_reg  <= '0;
            cry_reg  <= '0;
            srx_reg  <= '0;
            sry_reg  <= '0;
            vol_reg  <= '0;
            brt_reg  <= '0;
            prev_reg <= MODE_CURSOR;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_ROTATION: rot_reg <= cfg_data[3:0];
                    REG_DIVIDER:  div_reg <= cfg_data[2:0];
                    REG_INVERT:   inv_reg <= cfg_data[0];
                    REG_SMOOTH:   fac_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.smooth)
            begin
                cfx_reg  <= sat32(smooth(cfx_reg, 64'(rx_reg), fac_reg));
                cfy_reg  <= sat32(smooth(cfy_reg, 64'(ry_reg), fac_reg));
                mfx_reg  <= sat32(smooth(mfx_seed, 64'(rx_reg), fac_reg));
                mfy_reg  <= sat32(smooth(mfy_seed, 64'(ry_reg), fac_reg));
                prev_reg <= mode_reg;
                if (mode_change)
                begin
                    case (mode_reg)
                        MODE_CURSOR:
                        begin
                            crx_reg <= '0;
                            cry_reg <= '0;
                        end
                        MODE_SCROLL:
                        begin
                            srx_reg <= '0;
                            sry_reg <= '0;
                        end
                        MODE_VOLUME: vol_reg <= '0;
                        default:     brt_reg <= '0;
                    endcase
                end
            end
            if (cmd.output_calc)
            begin
                case (mode_reg)
                    MODE_VOLUME:     vol_reg <= rem0;
                    MODE_BRIGHTNESS: brt_reg <= rem0;
                    MODE_SCROLL:
                    begin
                        srx_reg <= rem0;
                        sry_reg <= rem1;
                    end
                    default:
                    begin
                        crx_reg <= rem0;
                        cry_reg <= rem1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= move_x;
            y_reg    <= move_y;
            mode_reg <= mode_c;
        end
        if (cmd.rotate)
        begin
            rx_reg <= rx_c[47:0];
            ry_reg <= ry_c[47:0];
        end
        if (cmd.smooth)
        begin
            cx_reg <= sat32(smooth(cfx_reg, 64'(rx_reg), fac_reg));
            cy_reg <= sat32(smooth(cfy_reg, 64'(ry_reg), fac_reg));
        end
        if (cmd.mode)
        begin
            t0_reg <= t0[31:0];
            t1_reg <= t1[31:0];
        end
        if (cmd.output_calc)
        begin
            cursor_dx        <= (mode_reg == MODE_CURSOR) ? n0[7:0] : 8'sd0;
            cursor_dy        <= (mode_reg == MODE_CURSOR) ? n1[7:0] : 8'sd0;
            scroll_h         <= (mode_reg == MODE_SCROLL) ? n0[7:0] : 8'sd0;
            scroll_v         <= (mode_reg == MODE_SCROLL) ? n1[7:0] : 8'sd0;
            volume_steps     <= (mode_reg == MODE_VOLUME) ? n0[4:0] : 5'sd0;
            brightness_steps <= (mode_reg == MODE_BRIGHTNESS) ? n0[4:0] : 5'sd0;
            current_mode     <= mode_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/trackball_motion_mode_processor_core.sv =====
// top level of the trackball motion mode processor
// an input runs through the rotate, smooth, mode and output states
// before the result is valid; the next input transfer is taken in
// the cycle the result transfer completes, not before
// reset: asynchronous active low, clears filters and remainders,
// sets the previous mode to cursor and restores register defaults
`default_nettype none
module trackball_motion_mode_processor_core
    import tmmp_pkg::*;
#(
    parameter int ANGLE_COUNT   = ANGLE_COUNT_DEF,
    parameter int DIVIDER_COUNT = DIVIDER_COUNT_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_idx,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic signed [7:0] move_x,
    input  wire logic signed [7:0] move_y,
    input  wire logic              want_volume,
    input  wire logic              want_brightness,
    input  wire logic              want_scroll,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [7:0]      cursor_dx,
    output logic signed [7:0]      cursor_dy,
    output logic signed [7:0]      scroll_h,
    output logic signed [7:0]      scroll_v,
    output logic signed [4:0]      volume_steps,
    output logic signed [4:0]      brightness_steps,
    output logic [1:0]             current_mode
);

    tmmp_cmd_t cmd;

    tmmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tmmp_datapath #(
        .ANGLE_COUNT   (ANGLE_COUNT),
        .DIVIDER_COUNT (DIVIDER_COUNT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_data         (cfg_data),
        .move_x           (move_x),
        .move_y           (move_y),
        .want_volume      (want_volume),
        .want_brightness  (want_brightness),
        .want_scroll      (want_scroll),
        .cursor_dx        (cursor_dx),
        .cursor_dy        (cursor_dy),
        .scroll_h         (scroll_h),
        .scroll_v         (scroll_v),
        .volume_steps     (volume_steps),
        .brightness_steps (brightness_steps),
        .current_mode     (current_mode)
    );

endmodule
`default_nettype wire
